// File: design/pelw_pkg.sv
`timescale 1ns / 1ps

package pelw_pkg;

	localparam int QUEUE_DEPTH_DEF  = 8;
	localparam int NUM_SLOTS_DEF    = 5;
	localparam int RECORD_BYTES_DEF = 8;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_WRITE_GAP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOG_BASE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INDEX     = 2'd2;

	localparam logic [7:0] WRITE_GAP_RST = 8'd5;
	localparam logic [7:0] LOG_BASE_RST  = 8'h08;
	localparam logic [7:0] INDEX_RST     = 8'h01;
	localparam logic [7:0] ELAPSED_MAX   = 8'hFF;

	localparam int ITEM_FIFO_DEPTH = 2;

	// one input transaction after classification
	typedef struct packed {
		logic        tick;
		logic [63:0] record;
	} item_t;

	// sequencer decision, waiting for the record data to come out of the ring RAM
	typedef struct packed {
		logic       push_accepted;
		logic       write_valid;
		logic [7:0] write_addr;
		logic       from_snap;
		logic [2:0] byte_sel;
		logic [7:0] idx_byte;
		logic       mirror_valid;
		logic [2:0] mirror_slot;
		logic       led_trigger;
		logic       busy_res;
	} decision_t;

	typedef struct packed {
		logic        push_accepted;
		logic        write_valid;
		logic [7:0]  write_addr;
		logic [7:0]  write_byte;
		logic        mirror_valid;
		logic [2:0]  mirror_slot;
		logic [63:0] mirror_record;
		logic        led_trigger;
		logic        busy_res;
	} result_t;

endpackage

// File: design/pelw_if.sv
`timescale 1ns / 1ps

interface pelw_in_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [63:0] record;

	modport source (output valid, kind, record, input ready);
	modport sink (input valid, kind, record, output ready);
endinterface

interface pelw_out_if;
	logic        valid;
	logic        ready;
	logic        push_accepted;
	logic        write_valid;
	logic [7:0]  write_addr;
	logic [7:0]  write_byte;
	logic        mirror_valid;
	logic [2:0]  mirror_slot;
	logic [63:0] mirror_record;
	logic        led_trigger;
	logic        busy_res;

	modport source (output valid, push_accepted, write_valid, write_addr, write_byte,
		mirror_valid, mirror_slot, mirror_record, led_trigger, busy_res, input ready);
	modport sink (input valid, push_accepted, write_valid, write_addr, write_byte,
		mirror_valid, mirror_slot, mirror_record, led_trigger, busy_res, output ready);
endinterface

// File: design/pelw_ram.sv
`timescale 1ns / 1ps

module pelw_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: design/pelw_front.sv
`timescale 1ns / 1ps

module pelw_front import pelw_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	pelw_in_if.sink    in_ch,
	output logic       item_valid,
	input  logic       item_ready,
	output item_t      item
);

	localparam int PW = $clog2(ITEM_FIFO_DEPTH);
	localparam int CW = $clog2(ITEM_FIFO_DEPTH + 1);

	item_t         ent_q [ITEM_FIFO_DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;
	logic          push;
	logic          pop;

	assign in_ch.ready = (cnt_q != CW'(ITEM_FIFO_DEPTH));
	assign push        = in_ch.valid && in_ch.ready;
	assign item_valid  = (cnt_q != '0);
	assign pop         = item_valid && item_ready;
	assign item        = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= '{tick: in_ch.kind, record: in_ch.record};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(ITEM_FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(ITEM_FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// File: design/pelw_back.sv
`timescale 1ns / 1ps

module pelw_back import pelw_pkg::*; #(
	parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
	parameter int NUM_SLOTS    = NUM_SLOTS_DEF,
	parameter int RECORD_BYTES = RECORD_BYTES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  item_t                 item,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	pelw_out_if.source            out_ch
);

	localparam int QW = $clog2(QUEUE_DEPTH);
	localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int OW = $clog2(RECORD_BYTES + 1);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_DATA,
		PH_INDEX,
		PH_COOL
	} phase_t;

	phase_t        phase_q, phase_nx;
	logic [QW-1:0] head_q, head_nx;
	logic [QW-1:0] tail_q, tail_nx;
	logic [7:0]    elapsed_q, elapsed_nx;
	logic [OW-1:0] off_q, off_nx;
	logic [SW-1:0] slot_q, slot_nx;
	logic [7:0]    gap_q, base_q, idx_addr_q;

	logic [QW-1:0] head_inc, tail_inc;
	logic [SW-1:0] slot_inc;
	logic [OW-1:0] off_inc;
	logic [7:0]    elapsed_inc;
	logic          gap_ok;
	logic          step;
	logic          ram_we, ram_re;
	logic [63:0]   ram_rdata;

	decision_t     dec;
	decision_t     dec_s1;
	logic          valid_s1;
	logic          take_s1;
	logic [63:0]   snap_q;
	result_t       res_q;
	logic          res_valid_q;

	assign take_s1    = valid_s1 && (!res_valid_q || out_ch.ready);
	assign item_ready = !valid_s1 || take_s1;
	assign step       = item_valid && item_ready;

	assign head_inc    = (head_q == QW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign tail_inc    = (tail_q == QW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
	assign slot_inc    = (slot_q == SW'(NUM_SLOTS - 1)) ? '0 : slot_q + 1'b1;
	assign off_inc     = off_q + 1'b1;
	assign elapsed_inc = (elapsed_q == ELAPSED_MAX) ? elapsed_q : elapsed_q + 8'd1;
	assign gap_ok      = (elapsed_inc >= gap_q);

	pelw_ram #(
		.WIDTH(64),
		.DEPTH(QUEUE_DEPTH)
	) u_ring (
		.clk  (clk),
		.we   (ram_we),
		.waddr(head_q),
		.wdata(item.record),
		.re   (ram_re),
		.raddr(tail_q),
		.rdata(ram_rdata)
	);

	always_comb begin
		phase_nx   = phase_q;
		head_nx    = head_q;
		tail_nx    = tail_q;
		elapsed_nx = elapsed_q;
		off_nx     = off_q;
		slot_nx    = slot_q;
		ram_we     = 1'b0;
		ram_re     = 1'b0;
		dec        = '0;

		if (!item.tick) begin
			if (head_inc != tail_q) begin
				ram_we            = step;
				head_nx           = head_inc;
				dec.push_accepted = 1'b1;
			end
		end else begin
			elapsed_nx = elapsed_inc;
			unique case (phase_q)
				PH_IDLE: begin
					if (head_q != tail_q) begin
						ram_re           = step;
						tail_nx          = tail_inc;
						dec.mirror_valid = 1'b1;
						dec.mirror_slot  = 3'(slot_q);
						dec.led_trigger  = 1'b1;
						off_nx           = '0;
						phase_nx         = PH_DATA;
					end
				end
				PH_DATA: begin
					if (gap_ok) begin
						dec.write_valid = 1'b1;
						dec.write_addr  = base_q + 8'(32'(slot_q) * RECORD_BYTES) + 8'(off_q);
						dec.from_snap   = 1'b1;
						dec.byte_sel    = 3'(off_q);
						off_nx          = off_inc;
						elapsed_nx      = '0;
						if (off_inc >= OW'(RECORD_BYTES)) begin
							phase_nx = PH_INDEX;
						end
					end
				end
				PH_INDEX: begin
					if (gap_ok) begin
						slot_nx         = slot_inc;
						dec.write_valid = 1'b1;
						dec.write_addr  = idx_addr_q;
						dec.idx_byte    = 8'(slot_inc);
						elapsed_nx      = '0;
						phase_nx        = PH_COOL;
					end
				end
				PH_COOL: begin
					if (gap_ok) begin
						phase_nx = PH_IDLE;
					end
				end
				default: phase_nx = PH_IDLE;
			endcase
		end
		dec.busy_res = (phase_nx != PH_IDLE);
	end

	// sequencer state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			head_q     <= '0;
			tail_q     <= '0;
			elapsed_q  <= ELAPSED_MAX;
			off_q      <= '0;
			slot_q     <= '0;
			gap_q      <= WRITE_GAP_RST;
			base_q     <= LOG_BASE_RST;
			idx_addr_q <= INDEX_RST;
		end else begin
			if (step) begin
				phase_q   <= phase_nx;
				head_q    <= head_nx;
				tail_q    <= tail_nx;
				elapsed_q <= elapsed_nx;
				off_q     <= off_nx;
				slot_q    <= slot_nx;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					REG_WRITE_GAP: gap_q      <= cfg_data;
					REG_LOG_BASE:  base_q     <= cfg_data;
					REG_INDEX:     idx_addr_q <= cfg_data;
					default:       ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (step) begin
				valid_s1 <= 1'b1;
			end else if (take_s1) begin
				valid_s1 <= 1'b0;
			end
			if (take_s1) begin
				res_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// a data byte always follows its dequeue, so snap_q is loaded by then
	always_ff @(posedge clk) begin
		if (step) begin
			dec_s1 <= dec;
		end
		if (take_s1) begin
			if (dec_s1.mirror_valid) begin
				snap_q <= ram_rdata;
			end
			res_q.push_accepted <= dec_s1.push_accepted;
			res_q.write_valid   <= dec_s1.write_valid;
			res_q.write_addr    <= dec_s1.write_addr;
			res_q.write_byte    <= dec_s1.from_snap ? snap_q[{dec_s1.byte_sel, 3'b000} +: 8]
				: dec_s1.idx_byte;
			res_q.mirror_valid  <= dec_s1.mirror_valid;
			res_q.mirror_slot   <= dec_s1.mirror_slot;
			res_q.mirror_record <= dec_s1.mirror_valid ? ram_rdata : '0;
			res_q.led_trigger   <= dec_s1.led_trigger;
			res_q.busy_res      <= dec_s1.busy_res;
		end
	end

	assign out_ch.valid         = res_valid_q;
	assign out_ch.push_accepted = res_q.push_accepted;
	assign out_ch.write_valid   = res_q.write_valid;
	assign out_ch.write_addr    = res_q.write_addr;
	assign out_ch.write_byte    = res_q.write_byte;
	assign out_ch.mirror_valid  = res_q.mirror_valid;
	assign out_ch.mirror_slot   = res_q.mirror_slot;
	assign out_ch.mirror_record = res_q.mirror_record;
	assign out_ch.led_trigger   = res_q.led_trigger;
	assign out_ch.busy_res      = res_q.busy_res;

endmodule

// File: design/paced_eeprom_log_writer.sv
`timescale 1ns / 1ps

// Channel   Dir  Payload
// in_ch     in   kind, record                        (valid/ready)
// out_ch    out  push_accepted .. busy_res, one per input transaction (valid/ready)
// cfg_*     in   cfg_we, cfg_index, cfg_data         (write only, no handshake)
//
// One transaction per cycle sustained while out_ch is ready; an input passes the
// input queue, the sequencer decision with ring RAM read and the result register.
// arst_n clears all control state; the ring RAM contents are left as they are.
// Either side may stall on its own: the two-entry input queue and the result
// register absorb backpressure without losing throughput.
module paced_eeprom_log_writer import pelw_pkg::*; #(
	parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
	parameter int NUM_SLOTS    = NUM_SLOTS_DEF,
	parameter int RECORD_BYTES = RECORD_BYTES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	pelw_in_if.sink               in_ch,
	pelw_out_if.source            out_ch,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic  item_valid;
	logic  item_ready;
	item_t item;

	pelw_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item      (item)
	);

	pelw_back #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.NUM_SLOTS   (NUM_SLOTS),
		.RECORD_BYTES(RECORD_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item      (item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_ch    (out_ch)
	);

endmodule

// File: tb/sv/paced_eeprom_log_writer_test.sv
`timescale 1ns / 1ps

module paced_eeprom_log_writer_test;
	import pelw_pkg::*;

	localparam logic KIND_PUSH = 1'b0;
	localparam logic KIND_TICK = 1'b1;
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;
	localparam int DRAIN_CYCLES = 8;

	typedef enum logic [1:0] {SEQ_IDLE, SEQ_DATA, SEQ_INDEX, SEQ_COOL} seq_phase_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	pelw_in_if in_ch();
	pelw_out_if out_ch();

	paced_eeprom_log_writer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	// shadow of the log writer
	logic [63:0] ring_shadow [QUEUE_DEPTH_DEF];
	int          ring_head;
	int          ring_tail;
	seq_phase_t  seq_phase;
	logic [7:0]  elapsed_ms;
	logic [3:0]  byte_offset;
	logic [2:0]  slot_index;
	logic [63:0] record_snap;
	logic [7:0]  gap_ms_cfg;
	logic [7:0]  base_addr_cfg;
	logic [7:0]  index_addr_cfg;

	item_t   log_items_pending[$];
	result_t log_results_due[$];
	item_t   next_item;
	int      items_queued = 0;
	int      items_taken = 0;
	int      mismatch_count = 0;
	int      send_idle_pct = 0;
	int      recv_stall_pct = 0;

	function automatic result_t predict_log_item(input logic kind, input logic [63:0] rec);
		result_t res;
		logic [2:0] off;
		logic gap_ok;
		res = '0;
		if (kind == KIND_PUSH) begin
			if ((ring_head + 1) % QUEUE_DEPTH_DEF != ring_tail) begin
				ring_shadow[ring_head] = rec;
				ring_head = (ring_head + 1) % QUEUE_DEPTH_DEF;
				res.push_accepted = 1'b1;
			end
		end else begin
			if (elapsed_ms != ELAPSED_MAX)
				elapsed_ms = elapsed_ms + 8'd1;
			gap_ok = elapsed_ms >= gap_ms_cfg;
			case (seq_phase)
				SEQ_IDLE: begin
					if (ring_head != ring_tail) begin
						record_snap = ring_shadow[ring_tail];
						ring_tail = (ring_tail + 1) % QUEUE_DEPTH_DEF;
						res.mirror_valid = 1'b1;
						res.mirror_slot = slot_index;
						res.mirror_record = record_snap;
						res.led_trigger = 1'b1;
						byte_offset = '0;
						seq_phase = SEQ_DATA;
					end
				end
				SEQ_DATA: begin
					if (gap_ok) begin
						off = 3'(byte_offset % RECORD_BYTES_DEF);
						res.write_valid = 1'b1;
						res.write_addr = 8'(base_addr_cfg + slot_index * RECORD_BYTES_DEF + off);
						res.write_byte = 8'(record_snap >> (8 * off));
						byte_offset = {1'b0, off} + 4'd1;
						elapsed_ms = '0;
						if (byte_offset >= RECORD_BYTES_DEF)
							seq_phase = SEQ_INDEX;
					end
				end
				SEQ_INDEX: begin
					if (gap_ok) begin
						slot_index = 3'((slot_index + 1) % NUM_SLOTS_DEF);
						res.write_valid = 1'b1;
						res.write_addr = index_addr_cfg;
						res.write_byte = {5'b0, slot_index};
						elapsed_ms = '0;
						seq_phase = SEQ_COOL;
					end
				end
				default: begin
					if (gap_ok)
						seq_phase = SEQ_IDLE;
				end
			endcase
		end
		res.busy_res = seq_phase != SEQ_IDLE;
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t ns: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic check_field(input string field, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s is %h, expected %h", field, got, want));
	endtask

	// input side: one transaction per accepted item, random idle cycles
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.kind <= KIND_PUSH;
			in_ch.record <= '0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				log_results_due.push_back(predict_log_item(in_ch.kind, in_ch.record));
				items_taken++;
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (log_items_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					next_item = log_items_pending.pop_front();
					in_ch.valid <= 1'b1;
					in_ch.kind <= next_item.tick;
					in_ch.record <= next_item.record;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (log_results_due.size() == 0) begin
					report_mismatch("result transaction with nothing expected");
				end else begin
					check_field("push_accepted", out_ch.push_accepted,
						log_results_due[0].push_accepted);
					check_field("write_valid", out_ch.write_valid, log_results_due[0].write_valid);
					check_field("write_addr", out_ch.write_addr, log_results_due[0].write_addr);
					check_field("write_byte", out_ch.write_byte, log_results_due[0].write_byte);
					check_field("mirror_valid", out_ch.mirror_valid,
						log_results_due[0].mirror_valid);
					check_field("mirror_slot", out_ch.mirror_slot, log_results_due[0].mirror_slot);
					check_field("mirror_record", out_ch.mirror_record,
						log_results_due[0].mirror_record);
					check_field("led_trigger", out_ch.led_trigger, log_results_due[0].led_trigger);
					check_field("busy_res", out_ch.busy_res, log_results_due[0].busy_res);
					void'(log_results_due.pop_front());
				end
			end
			out_ch.ready <= $urandom_range(0, 99) >= recv_stall_pct;
		end
	end

	task automatic queue_item(input logic kind, input logic [63:0] rec);
		item_t it;
		it.tick = kind;
		it.record = rec;
		log_items_pending.push_back(it);
		items_queued++;
	endtask

	task automatic wait_drained();
		while (items_taken != items_queued || log_results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_WRITE_GAP: gap_ms_cfg = value;
			REG_LOG_BASE: base_addr_cfg = value;
			REG_INDEX: index_addr_cfg = value;
			default: ;
		endcase
	endtask

	task automatic set_idling(input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
	endtask

	// mostly ticks with records sprinkled in; occasional push bursts overrun the queue
	task automatic run_random_phase(input int n_items, input int push_pct);
		int count;
		int r;
		int burst;
		logic [63:0] rec;
		count = 0;
		while (count < n_items) begin
			r = $urandom_range(0, 99);
			burst = (r < 4) ? $urandom_range(4, 9) : (r < 4 + push_pct) ? 1 : 0;
			if (burst == 0) begin
				queue_item(KIND_TICK, {$urandom, $urandom});
				count++;
			end
			repeat (burst) begin
				case ($urandom_range(0, 9))
					0: rec = '0;
					1: rec = '1;
					default: rec = {$urandom, $urandom};
				endcase
				queue_item(KIND_PUSH, rec);
				count++;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_WRITE_GAP;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.kind = KIND_PUSH;
		in_ch.record = '0;
		out_ch.ready = 1'b0;
		ring_head = 0;
		ring_tail = 0;
		seq_phase = SEQ_IDLE;
		elapsed_ms = ELAPSED_MAX;
		byte_offset = '0;
		slot_index = '0;
		record_snap = '0;
		gap_ms_cfg = WRITE_GAP_RST;
		base_addr_cfg = LOG_BASE_RST;
		index_addr_cfg = INDEX_RST;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// reset register values; tick on empty queue, then overfill the queue
		set_idling(0, 0);
		queue_item(KIND_TICK, 64'hFFFF_FFFF_FFFF_FFFF);
		queue_item(KIND_PUSH, 64'h0000_0000_0000_0000);
		queue_item(KIND_PUSH, 64'hFFFF_FFFF_FFFF_FFFF);
		queue_item(KIND_PUSH, 64'h0123_4567_89AB_CDEF);
		queue_item(KIND_PUSH, 64'hAAAA_AAAA_AAAA_AAAA);
		queue_item(KIND_PUSH, 64'h5555_5555_5555_5555);
		queue_item(KIND_PUSH, 64'h8000_0000_0000_0001);
		queue_item(KIND_PUSH, 64'hFF00_FF00_FF00_FF00);
		queue_item(KIND_PUSH, 64'h00FF_00FF_00FF_00FF);
		queue_item(KIND_PUSH, 64'hDEAD_BEEF_CAFE_F00D);
		repeat (15) queue_item(KIND_TICK, 64'h0);
		wait_drained();

		// zero gap, top addresses so slot addresses wrap
		write_register(REG_WRITE_GAP, 8'd0);
		write_register(REG_LOG_BASE, 8'hFF);
		write_register(REG_INDEX, 8'hFF);
		write_register(REG_UNMAPPED, 8'($urandom));
		run_random_phase(35, 20);
		wait_drained();

		write_register(REG_WRITE_GAP, 8'd1);
		write_register(REG_LOG_BASE, 8'h00);
		write_register(REG_INDEX, 8'h00);
		set_idling(60, 0);
		run_random_phase(35, 25);
		wait_drained();

		write_register(REG_WRITE_GAP, 8'd2);
		write_register(REG_LOG_BASE, 8'($urandom));
		write_register(REG_INDEX, 8'($urandom));
		set_idling(0, 60);
		run_random_phase(35, 15);
		wait_drained();

		write_register(REG_WRITE_GAP, 8'd3);
		write_register(REG_LOG_BASE, 8'($urandom_range(224, 255)));
		write_register(REG_INDEX, 8'h80);
		set_idling(15, 15);
		run_random_phase(35, 10);
		wait_drained();

		// widest gap: elapsed time has to saturate before a write goes out
		write_register(REG_WRITE_GAP, 8'hFF);
		set_idling(60, 0);
		queue_item(KIND_PUSH, {$urandom, $urandom});
		repeat (260) queue_item(KIND_TICK, {$urandom, $urandom});
		wait_drained();

		write_register(REG_WRITE_GAP, 8'($urandom_range(0, 4)));
		write_register(REG_LOG_BASE, 8'($urandom));
		write_register(REG_INDEX, 8'($urandom));
		set_idling(15, 15);
		run_random_phase(40, 20);
		wait_drained();

		if (mismatch_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
